// ----- rtl/dbrs_pkg.sv -----
// ----------------------------------------------------------------------------
// dbrs_pkg
// Shared types and constants for the block-decomposed range sum unit.
// ----------------------------------------------------------------------------
package dbrs_pkg;

  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;
  localparam int CFG_W  = 11;
  localparam int TYPE_W = 2;

  localparam logic [CFG_W-1:0] LEN_RESET = 11'd1024;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_ASSIGN = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_PREFIX = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_RANGE  = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_NONE   = 2'd3;

  // status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  typedef struct packed {
    logic [TYPE_W-1:0]       req_type;
    logic [IDX_W-1:0]        index_lo;
    logic [IDX_W-1:0]        index_hi;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_REM,
    S_PLAN,
    S_ASG_RD,
    S_ASG_WR,
    S_SEG_A,
    S_BLKS,
    S_SEG_C,
    S_DRAIN,
    S_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic capture;   // latch request, clear accumulator
    logic divide;    // block number of both indices
    logic split;     // offsets within block
    logic plan;      // walk endpoints
    logic el_rd;
    logic blk_rd;
    logic acc;       // reads issued now feed the accumulator
    logic el_inc;
    logic blk_inc;
    logic el_to_c;   // jump element pointer to the last partial block
    logic asg_wr;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              err;
    logic              rev;
    logic              same_blk;
    logic              has_mid;
    logic              el_last;
    logic              blk_last;
    logic              clr_last;
  } sts_t;

endpackage

// ----- rtl/dbrs_datapath.sv -----
// ----------------------------------------------------------------------------
// dbrs_datapath
// Element store, block sum store, index split, walk pointers and accumulator.
// ----------------------------------------------------------------------------
module dbrs_datapath import dbrs_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int BLOCK_SIZE = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  req_t             req,
  input  cmd_t             cmd,
  output sts_t             sts,
  output rsp_t             rsp
);

  localparam int NUM_BLOCKS = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int AW         = $clog2(DEPTH);
  localparam int BW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int OFF_W      = $clog2(BLOCK_SIZE);
  localparam int BSUM_W     = VAL_W + $clog2(BLOCK_SIZE);
  localparam int LEN_W      = ($clog2(DEPTH + 1) > CFG_W) ? $clog2(DEPTH + 1) : CFG_W;
  localparam int EXT_W      = ((AW > IDX_W) ? AW : IDX_W) + 1;
  // floor(n / BLOCK_SIZE) as (n * RECIP) >> SHIFT, exact for n < 2**IDX_W
  localparam int SHIFT      = IDX_W + $clog2(BLOCK_SIZE);
  localparam int RECIP      = ((2 ** SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int PW         = SHIFT + IDX_W;

  logic [CFG_W-1:0]        array_length;
  logic [LEN_W-1:0]        len_eff;
  logic                    lo_bad, hi_bad, err_c;

  logic [TYPE_W-1:0]       req_type;
  logic [IDX_W-1:0]        lo_q, hi_q;
  logic signed [VAL_W-1:0] value_q;
  logic                    err, rev;

  logic [PW-1:0]           prod_lo, prod_hi;
  logic [IDX_W-1:0]        q_lo, q_hi;
  logic [OFF_W-1:0]        r_lo, r_hi;

  logic                    same_c;
  logic                    same_blk, has_mid;
  logic [AW-1:0]           lo_addr, hi_addr, seg_a_end, segc_c;
  logic [AW-1:0]           el_ptr, el_end, segc;
  logic [BW-1:0]           blk_ptr, blk_end, q_lo_b;

  logic [AW-1:0]           clr_cnt;
  logic                    clr_in_blk;

  logic [VAL_W-1:0]        el_mem [DEPTH];
  logic [BSUM_W-1:0]       blk_mem [NUM_BLOCKS];
  logic [VAL_W-1:0]        el_rdata;
  logic [BSUM_W-1:0]       blk_rdata;
  logic                    el_we, blk_we;
  logic [AW-1:0]           el_waddr;
  logic [VAL_W-1:0]        el_wdata;
  logic [BW-1:0]           blk_waddr, blk_raddr;
  logic [BSUM_W-1:0]       blk_wdata;
  logic signed [BSUM_W-1:0] delta;
  logic                    el_acc_q, blk_acc_q;
  logic signed [SUM_W-1:0] acc;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= LEN_RESET;
    end else if (cfg_wr_en) begin
      array_length <= cfg_wr_data;
    end
  end

  assign len_eff = (LEN_W'(array_length) > LEN_W'(DEPTH)) ? LEN_W'(DEPTH)
                                                           : LEN_W'(array_length);
  assign lo_bad  = LEN_W'(req.index_lo) >= len_eff;
  assign hi_bad  = LEN_W'(req.index_hi) >= len_eff;

  always_comb begin
    unique case (req.req_type)
      REQ_ASSIGN: err_c = lo_bad;
      REQ_PREFIX: err_c = hi_bad;
      REQ_RANGE:  err_c = lo_bad | hi_bad;
      default:    err_c = 1'b0;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type <= req.req_type;
      lo_q     <= (req.req_type == REQ_PREFIX) ? '0 : req.index_lo;
      hi_q     <= req.index_hi;
      value_q  <= req.value;
      err      <= err_c;
      rev      <= (req.req_type == REQ_RANGE) && (req.index_lo > req.index_hi);
    end
  end

  // block number and offset of both indices
  assign prod_lo = PW'(lo_q) * PW'(RECIP);
  assign prod_hi = PW'(hi_q) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.divide) begin
      q_lo <= prod_lo[SHIFT +: IDX_W];
      q_hi <= prod_hi[SHIFT +: IDX_W];
    end
    if (cmd.split) begin
      r_lo <= OFF_W'(lo_q - q_lo * IDX_W'(BLOCK_SIZE));
      r_hi <= OFF_W'(hi_q - q_hi * IDX_W'(BLOCK_SIZE));
    end
  end

  assign lo_addr   = AW'(lo_q);
  assign hi_addr   = AW'(hi_q);
  assign q_lo_b    = BW'(q_lo);
  assign same_c    = (q_lo == q_hi);
  // end of the first partial block, or hi itself when both share a block
  assign seg_a_end = same_c ? hi_addr
                            : AW'(EXT_W'(lo_q) + EXT_W'(BLOCK_SIZE - 1) - EXT_W'(r_lo));
  assign segc_c    = AW'(hi_q - IDX_W'(r_hi));

  // walk pointers
  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      el_ptr   <= lo_addr;
      el_end   <= seg_a_end;
      segc     <= segc_c;
      blk_ptr  <= BW'(q_lo + IDX_W'(1));
      blk_end  <= BW'(q_hi - IDX_W'(1));
      same_blk <= same_c;
      has_mid  <= ((IDX_W + 1)'(q_lo) + (IDX_W + 1)'(2)) <= (IDX_W + 1)'(q_hi);
    end else begin
      if (cmd.el_to_c) begin
        el_ptr <= segc;
        el_end <= hi_addr;
      end else if (cmd.el_inc) begin
        el_ptr <= el_ptr + AW'(1);
      end
      if (cmd.blk_inc) begin
        blk_ptr <= blk_ptr + BW'(1);
      end
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign clr_in_blk = (AW + 1)'(clr_cnt) < (AW + 1)'(NUM_BLOCKS);

  // store ports
  assign delta     = BSUM_W'($signed(value_q)) - BSUM_W'($signed(el_rdata));
  assign el_we     = cmd.clr_wr | cmd.asg_wr;
  assign el_waddr  = cmd.clr_wr ? clr_cnt : lo_addr;
  assign el_wdata  = cmd.clr_wr ? '0 : value_q;
  assign blk_we    = (cmd.clr_wr & clr_in_blk) | cmd.asg_wr;
  assign blk_waddr = cmd.clr_wr ? BW'(clr_cnt) : q_lo_b;
  assign blk_wdata = cmd.clr_wr ? '0 : blk_rdata + delta;
  assign blk_raddr = (req_type == REQ_ASSIGN) ? q_lo_b : blk_ptr;

  always_ff @(posedge clk) begin
    if (el_we) begin
      el_mem[el_waddr] <= el_wdata;
    end
    if (cmd.el_rd) begin
      el_rdata <= el_mem[el_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    if (cmd.blk_rd) begin
      blk_rdata <= blk_mem[blk_raddr];
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      el_acc_q  <= 1'b0;
      blk_acc_q <= 1'b0;
    end else begin
      el_acc_q  <= cmd.el_rd & cmd.acc;
      blk_acc_q <= cmd.blk_rd & cmd.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= '0;
    end else if (el_acc_q) begin
      acc <= acc + SUM_W'($signed(el_rdata));
    end else if (blk_acc_q) begin
      acc <= acc + SUM_W'($signed(blk_rdata));
    end
  end

  // result register; acc stays zero for assignments and rejected requests
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.sum    <= acc;
      rsp.status <= err ? STAT_ERR : STAT_OK;
    end
  end

  assign sts.req_type = req_type;
  assign sts.err      = err;
  assign sts.rev      = rev;
  assign sts.same_blk = same_blk;
  assign sts.has_mid  = has_mid;
  assign sts.el_last  = (el_ptr == el_end);
  assign sts.blk_last = (blk_ptr == blk_end);
  assign sts.clr_last = (clr_cnt == AW'(DEPTH - 1));

endmodule

// ----- rtl/dbrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// dbrs_ctrl
// Request sequencer: clearing pass, index split, store walk, result handoff.
// ----------------------------------------------------------------------------
module dbrs_ctrl import dbrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  ctl_state_t state, state_next;
  logic       out_free;
  logic       skip;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign skip      = sts.err || sts.rev || (sts.req_type == REQ_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:   if (req_valid) state_next = S_DIV;
      S_DIV:    state_next = S_REM;
      S_REM:    state_next = S_PLAN;
      S_PLAN: begin
        if (skip) begin
          state_next = S_FINISH;
        end else if (sts.req_type == REQ_ASSIGN) begin
          state_next = S_ASG_RD;
        end else begin
          state_next = S_SEG_A;
        end
      end
      S_ASG_RD: state_next = S_ASG_WR;
      S_ASG_WR: state_next = S_FINISH;
      S_SEG_A: begin
        if (sts.el_last) begin
          if (sts.same_blk) begin
            state_next = S_DRAIN;
          end else if (sts.has_mid) begin
            state_next = S_BLKS;
          end else begin
            state_next = S_SEG_C;
          end
        end
      end
      S_BLKS:   if (sts.blk_last) state_next = S_SEG_C;
      S_SEG_C:  if (sts.el_last) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR:  cmd.clr_wr = 1'b1;
      S_IDLE:   cmd.capture = req_valid;
      S_DIV:    cmd.divide = 1'b1;
      S_REM:    cmd.split = 1'b1;
      S_PLAN:   cmd.plan = 1'b1;
      S_ASG_RD: begin
        cmd.el_rd  = 1'b1;
        cmd.blk_rd = 1'b1;
      end
      S_ASG_WR: cmd.asg_wr = 1'b1;
      S_SEG_A: begin
        cmd.el_rd = 1'b1;
        cmd.acc   = 1'b1;
        if (sts.el_last) begin
          cmd.el_to_c = !sts.same_blk && !sts.has_mid;
        end else begin
          cmd.el_inc = 1'b1;
        end
      end
      S_BLKS: begin
        cmd.blk_rd = 1'b1;
        cmd.acc    = 1'b1;
        if (sts.blk_last) begin
          cmd.el_to_c = 1'b1;
        end else begin
          cmd.blk_inc = 1'b1;
        end
      end
      S_SEG_C: begin
        cmd.el_rd  = 1'b1;
        cmd.acc    = 1'b1;
        cmd.el_inc = !sts.el_last;
      end
      S_DRAIN:  cmd = '0;
      S_FINISH: cmd.out_load = out_free;
      default:  cmd = '0;
    endcase
  end

  // result handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> rsp_valid)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(rsp_valid && rsp_stall))
    else $error("result overwritten while stalled");

  a_dual_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.el_rd && cmd.blk_rd) |-> (state == S_ASG_RD))
    else $error("both stores read outside assignment");

  a_accept_flow: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DIV))
    else $error("accepted request not started");

endmodule

// ----- rtl/block_decomposed_range_sum_unit.sv -----
// Flow: one request at a time; requests stall until the sequencer is idle again.
//   Each request is captured, divided, split and planned; assignments then read and
//   write both stores, queries walk elements and middle blocks, and rejected or empty
//   requests skip to the result. Each store has a single read port. The next request
//   is accepted once a result waits. Reset: synchronous; a clearing pass over all DEPTH
//   entries zeroes both stores, with requests stalled meanwhile. Length register resets to 1024.
// ----------------------------------------------------------------------------
// block_decomposed_range_sum_unit
// Point assignment and prefix/range sums over a blocked array with block sums.
// ----------------------------------------------------------------------------
module block_decomposed_range_sum_unit import dbrs_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int BLOCK_SIZE = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  cmd_t cmd;
  sts_t sts;

  dbrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dbrs_datapath #(
    .DEPTH      (DEPTH),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .cmd         (cmd),
    .sts         (sts),
    .rsp         (rsp)
  );

endmodule
